@@ hdl/ilp_pkg.sv @@
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and helpers for the integer literal parser
// Character codes, phase encoding, digit decode and the result record.
// ----------------------------------------------------------------------------
package ilp_pkg;

  // Width of the accumulated magnitude
  localparam int unsigned ValueBits = 32;
  // Width of the number output field
  localparam int unsigned NumBits   = 32;

  // Character codes
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChLowB  = 8'h62;

  // Literal phase, one-hot
  typedef enum logic [7:0] {
    PhIdle      = 8'b0000_0001,
    PhAfterSign = 8'b0000_0010,
    PhZero      = 8'b0000_0100,
    PhPfxX      = 8'b0000_1000,
    PhPfxB      = 8'b0001_0000,
    PhDec       = 8'b0010_0000,
    PhHex       = 8'b0100_0000,
    PhBin       = 8'b1000_0000
  } phase_e;

  // Radix of the digit being accumulated
  typedef enum logic [1:0] {
    BaseDec = 2'd0,
    BaseHex = 2'd1,
    BaseBin = 2'd2
  } base_e;

  // Decoded character as a hex digit
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // One parse result
  typedef struct packed {
    logic               parsed_ok;
    logic [NumBits-1:0] number;
    logic [7:0]         consumed;
    logic               overflowed;
  } result_t;

  // Map a character to a hex digit value, any case
  function automatic digit_t decode_digit(logic [7:0] c);
    digit_t d;
    d.valid = 1'b0;
    d.value = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      d.valid = 1'b1;
      d.value = 4'(c - ChZero);
    end else if (c >= ChLowA && c <= ChLowF) begin
      d.valid = 1'b1;
      d.value = 4'(c - ChLowA + 8'd10);
    end else if (c >= ChUpA && c <= ChUpF) begin
      d.valid = 1'b1;
      d.value = 4'(c - ChUpA + 8'd10);
    end
    return d;
  endfunction

endpackage

@@ hdl/ilp_in_stage.sv @@
// ----------------------------------------------------------------------------
// ilp_in_stage: input register
// Holds one accepted character transaction until the core takes it.
// ----------------------------------------------------------------------------
module ilp_in_stage import ilp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] char_i,
  input  logic       start_i,
  input  logic       allow_neg_i,
  input  logic       take_i,       // core consumes the held character
  output logic       valid_o,
  output logic [7:0] char_o,
  output logic       start_o,
  output logic       allow_neg_o
);

  logic       vld_q, vld_d;
  logic [7:0] char_q;
  logic       start_q;
  logic       allow_neg_q;
  logic       load;

  assign ready_o = !vld_q || take_i;
  assign load    = valid_i && ready_o;
  assign vld_d   = load || (vld_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q      <= char_i;
      start_q     <= start_i;
      allow_neg_q <= allow_neg_i;
    end
  end

  assign valid_o     = vld_q;
  assign char_o      = char_q;
  assign start_o     = start_q;
  assign allow_neg_o = allow_neg_q;

endmodule

@@ hdl/ilp_core.sv @@
// ----------------------------------------------------------------------------
// ilp_core: literal state machine and accumulator
// Steps the parse state by one character per cycle while step_i is high and forms the result.
// ----------------------------------------------------------------------------
module ilp_core import ilp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,       // one character processed this cycle
  input  logic [7:0] char_i,
  input  logic       start_i,
  input  logic       allow_neg_i,
  output logic       emit_o,
  output result_t    result_o
);

  localparam int unsigned AccBits = ValueBits + 4;

  phase_e               phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic [ValueBits-1:0] mag_q, mag_d;
  logic [7:0]           cnt_q, cnt_d;
  logic                 wrap_q, wrap_d;
  logic                 neg_ok_q, neg_ok_d;
  logic                 emit;
  result_t              result;

  always_comb begin
    phase_e               cur_phase;
    logic                 cur_neg;
    logic [ValueBits-1:0] cur_mag;
    logic [7:0]           cur_cnt;
    logic                 cur_wrap;
    logic                 take_sign;
    base_e                base;
    digit_t               dig;
    logic                 dig_ok;
    logic [AccBits-1:0]   acc;
    logic [AccBits-1:0]   mag_ext;
    logic [8:0]           cnt_inc1;
    logic [8:0]           cnt_inc2;
    logic [7:0]           cnt_sat1;
    logic [7:0]           cnt_sat2;
    logic [ValueBits-1:0] val;
    logic                 ok;

    // Start discards any literal in flight
    cur_phase = phase_q;
    cur_neg   = neg_q;
    cur_mag   = mag_q;
    cur_cnt   = cnt_q;
    cur_wrap  = wrap_q;
    neg_ok_d  = neg_ok_q;
    take_sign = 1'b0;
    if (start_i) begin
      cur_phase = PhAfterSign;
      cur_neg   = 1'b0;
      cur_mag   = '0;
      cur_cnt   = 8'd0;
      cur_wrap  = 1'b0;
      neg_ok_d  = allow_neg_i;
      take_sign = allow_neg_i && (char_i == ChMinus);
    end

    // Radix for this character
    unique case (cur_phase)
      PhPfxX, PhHex: base = BaseHex;
      PhPfxB, PhBin: base = BaseBin;
      default:       base = BaseDec;
    endcase

    dig = decode_digit(char_i);
    unique case (base)
      BaseHex: dig_ok = dig.valid;
      BaseBin: dig_ok = dig.valid && (dig.value < 4'd2);
      default: dig_ok = dig.valid && (dig.value < 4'd10);
    endcase

    // magnitude * base + digit, with headroom to spot the wrap
    mag_ext = AccBits'(cur_mag);
    unique case (base)
      BaseHex: acc = (mag_ext << 4) + AccBits'(dig.value);
      BaseBin: acc = (mag_ext << 1) + AccBits'(dig.value);
      default: acc = (mag_ext << 3) + (mag_ext << 1) + AccBits'(dig.value);
    endcase

    // Saturating consumed count
    cnt_inc1 = {1'b0, cur_cnt} + 9'd1;
    cnt_inc2 = {1'b0, cur_cnt} + 9'd2;
    cnt_sat1 = cnt_inc1[8] ? 8'hFF : cnt_inc1[7:0];
    cnt_sat2 = cnt_inc2[8] ? 8'hFF : cnt_inc2[7:0];

    phase_d = cur_phase;
    neg_d   = cur_neg;
    mag_d   = cur_mag;
    cnt_d   = cur_cnt;
    wrap_d  = cur_wrap;
    emit    = 1'b0;
    ok      = 1'b0;

    if (take_sign) begin
      neg_d = 1'b1;
      cnt_d = cnt_sat1;
    end else begin
      unique case (cur_phase)
        PhAfterSign: begin
          if (char_i == ChZero) begin
            cnt_d   = cnt_sat1;
            phase_d = PhZero;
          end else if (dig_ok) begin
            mag_d   = acc[ValueBits-1:0];
            wrap_d  = cur_wrap || (acc[AccBits-1:ValueBits] != '0);
            cnt_d   = cnt_sat1;
            phase_d = PhDec;
          end else begin
            emit = 1'b1;
          end
        end
        PhZero: begin
          if (char_i == ChLowX) begin
            phase_d = PhPfxX;
          end else if (char_i == ChLowB) begin
            phase_d = PhPfxB;
          end else if (dig_ok) begin
            mag_d   = acc[ValueBits-1:0];
            wrap_d  = cur_wrap || (acc[AccBits-1:ValueBits] != '0);
            cnt_d   = cnt_sat1;
            phase_d = PhDec;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PhPfxX, PhPfxB: begin
          // prefix letter only counts once a digit follows
          if (dig_ok) begin
            mag_d   = acc[ValueBits-1:0];
            wrap_d  = cur_wrap || (acc[AccBits-1:ValueBits] != '0);
            cnt_d   = cnt_sat2;
            phase_d = (cur_phase == PhPfxX) ? PhHex : PhBin;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        PhDec, PhHex, PhBin: begin
          if (dig_ok) begin
            mag_d  = acc[ValueBits-1:0];
            wrap_d = cur_wrap || (acc[AccBits-1:ValueBits] != '0);
            cnt_d  = cnt_sat1;
          end else begin
            emit = 1'b1;
            ok   = 1'b1;
          end
        end
        default: begin
          // idle: characters without start are dropped
        end
      endcase
    end

    if (emit) begin
      phase_d = PhIdle;
    end

    // Result record
    val = cur_neg ? (ValueBits'(0) - cur_mag) : cur_mag;
    if (ok) begin
      result.parsed_ok  = 1'b1;
      result.number     = NumBits'($signed(val));
      result.consumed   = cur_cnt;
      result.overflowed = cur_wrap;
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      neg_q    <= 1'b0;
      mag_q    <= '0;
      cnt_q    <= 8'd0;
      wrap_q   <= 1'b0;
      neg_ok_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      neg_q    <= neg_d;
      mag_q    <= mag_d;
      cnt_q    <= cnt_d;
      wrap_q   <= wrap_d;
      neg_ok_q <= neg_ok_d;
    end
  end

  assign emit_o   = step_i && emit;
  assign result_o = result;

endmodule

@@ hdl/ilp_out_stage.sv @@
// ----------------------------------------------------------------------------
// ilp_out_stage: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module ilp_out_stage import ilp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,       // new result this cycle
  input  result_t result_i,
  output logic    free_o,       // register can take a result now
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = free_o ? load_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= result_i;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

@@ hdl/integer_literal_parser.sv @@
// ----------------------------------------------------------------------------
// integer_literal_parser: streaming decimal / hex / binary literal parser
// Parses an optionally signed integer literal one character per transaction.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser
//  s_axis    in   [7:0] char_code                [0] start_req [1] allow_negative
//  m_axis    out  [31:0] number [39:32] consumed [0] parsed_ok [1] overflowed
//
//  One character per cycle while the result register has room. A result is
//  registered: the character that ends the literal passes the input register,
//  then the parse logic into the result register.
//  Reset clears the parse state to idle and empties both registers.
//  A stalled result register holds the character in the input register;
//  s_axis_tready stays high while that register can drain.
// ----------------------------------------------------------------------------
module integer_literal_parser import ilp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser,   // [0] start_req, [1] allow_negative
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] number, [39:32] consumed
  output logic [1:0]  m_axis_tuser    // [0] parsed_ok, [1] overflowed
);

  logic       in_vld;
  logic [7:0] in_char;
  logic       in_start;
  logic       in_allow_neg;
  logic       out_free;
  logic       step;
  logic       emit;
  result_t    core_res;
  result_t    out_res;

  // Parse a held character whenever the result register has room
  assign step = in_vld && out_free;

  ilp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .char_i      (s_axis_tdata),
    .start_i     (s_axis_tuser[0]),
    .allow_neg_i (s_axis_tuser[1]),
    .take_i      (step),
    .valid_o     (in_vld),
    .char_o      (in_char),
    .start_o     (in_start),
    .allow_neg_o (in_allow_neg)
  );

  ilp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .char_i      (in_char),
    .start_i     (in_start),
    .allow_neg_i (in_allow_neg),
    .emit_o      (emit),
    .result_o    (core_res)
  );

  ilp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (core_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {out_res.consumed, out_res.number};
  assign m_axis_tuser = {out_res.overflowed, out_res.parsed_ok};

endmodule

@@ dv/tb_integer_literal_parser.sv @@
// ----------------------------------------------------------------------------
// tb_integer_literal_parser: self-checking bench for the literal parser
// Streams characters into the parser, predicts each literal result with a
// cycle-free model of the parse, and compares every result transaction
// field by field. Directed literals first, then random literal streams with
// random idling on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_integer_literal_parser;
  import ilp_pkg::*;

  localparam int unsigned RadixDec   = 10;
  localparam int unsigned RadixHex   = 16;
  localparam int unsigned RadixBin   = 2;
  localparam int unsigned RandomItems = 950;
  localparam int unsigned LongHold   = 120;
  localparam int unsigned CycleLimit = 200_000;

  // Characters that end a literal
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLowG  = 8'h67;

  // Expected literal results and the parse state that produces them
  class literal_scoreboard;
    result_t              pending_results[$];
    int unsigned          mismatches;
    phase_e               phase;
    logic                 negative;
    logic                 neg_allowed;
    logic                 wrap_seen;
    logic [ValueBits-1:0] magnitude;
    logic [7:0]           count;

    function new();
      pending_results.delete();
      mismatches  = 0;
      phase       = PhIdle;
      negative    = 1'b0;
      neg_allowed = 1'b0;
      wrap_seen   = 1'b0;
      magnitude   = '0;
      count       = '0;
    endfunction

    // Digit value of c in the given radix, -1 if not a digit
    function int digit_value(logic [7:0] c, int unsigned radix);
      int d;
      d = -1;
      if (c inside {[ChZero:ChNine]}) d = int'(c - ChZero);
      else if (c inside {[ChLowA:ChLowF]}) d = int'(c - ChLowA) + 10;
      else if (c inside {[ChUpA:ChUpF]}) d = int'(c - ChUpA) + 10;
      if (d >= int'(radix)) d = -1;
      return d;
    endfunction

    // Saturating character count
    function void bump_count(int unsigned n);
      count = (int'(count) + n > 255) ? 8'd255 : count + 8'(n);
    endfunction

    // magnitude = magnitude * radix + d, wrapping, with the wrap flagged
    function void add_digit(int unsigned radix, int d);
      logic [63:0] full;
      full = 64'(magnitude) * radix + 64'(d);
      if ((full >> ValueBits) != 0) wrap_seen = 1'b1;
      magnitude = full[ValueBits-1:0];
    endfunction

    // Close the literal: a number, or the null result
    function void push_result(bit ok);
      result_t              r;
      logic [ValueBits-1:0] v;
      r = '0;
      if (ok) begin
        v            = negative ? -magnitude : magnitude;
        r.parsed_ok  = 1'b1;
        r.number     = NumBits'($signed(v));
        r.consumed   = count;
        r.overflowed = wrap_seen;
      end
      pending_results.push_back(r);
      phase = PhIdle;
    endfunction

    // One accepted character transaction
    function void note_char(logic [7:0] c, logic start, logic neg_ok);
      int          d;
      int unsigned radix;
      if (start) begin
        neg_allowed = neg_ok;
        negative    = 1'b0;
        magnitude   = '0;
        count       = '0;
        wrap_seen   = 1'b0;
        phase       = PhAfterSign;
        if (neg_ok && c == ChMinus) begin
          negative = 1'b1;
          bump_count(1);
          return;
        end
      end
      case (phase)
        PhAfterSign: begin
          if (c == ChZero) begin
            bump_count(1);
            phase = PhZero;
          end else begin
            d = digit_value(c, RadixDec);
            if (d < 0) push_result(1'b0);
            else begin
              add_digit(RadixDec, d);
              bump_count(1);
              phase = PhDec;
            end
          end
        end
        PhZero: begin
          if (c == ChLowX) phase = PhPfxX;
          else if (c == ChLowB) phase = PhPfxB;
          else begin
            d = digit_value(c, RadixDec);
            if (d < 0) push_result(1'b1);
            else begin
              add_digit(RadixDec, d);
              bump_count(1);
              phase = PhDec;
            end
          end
        end
        // first digit after a prefix also counts the prefix letter
        PhPfxX, PhPfxB: begin
          radix = (phase == PhPfxX) ? RadixHex : RadixBin;
          d = digit_value(c, radix);
          if (d < 0) push_result(1'b1);
          else begin
            add_digit(radix, d);
            bump_count(2);
            phase = (radix == RadixHex) ? PhHex : PhBin;
          end
        end
        PhDec, PhHex, PhBin: begin
          radix = (phase == PhDec) ? RadixDec : (phase == PhHex) ? RadixHex : RadixBin;
          d = digit_value(c, radix);
          if (d < 0) push_result(1'b1);
          else begin
            add_digit(radix, d);
            bump_count(1);
          end
        end
        default: ;  // idle: character ignored
      endcase
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    // One accepted result transaction
    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.parsed_ok !== want.parsed_ok)
        report($sformatf("parsed_ok exp %0b got %0b", want.parsed_ok, got.parsed_ok));
      if (got.number !== want.number)
        report($sformatf("number exp %0d got %0d",
                         $signed(want.number), $signed(got.number)));
      if (got.consumed !== want.consumed)
        report($sformatf("consumed exp %0d got %0d", want.consumed, got.consumed));
      if (got.overflowed !== want.overflowed)
        report($sformatf("overflowed exp %0b got %0b", want.overflowed, got.overflowed));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic [1:0]  s_axis_tuser;   // [0] start_req, [1] allow_negative
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] number, [39:32] consumed
  logic [1:0]  m_axis_tuser;   // [0] parsed_ok, [1] overflowed

  literal_scoreboard sb;
  result_t           observed;
  logic [7:0]        lit_q[$];
  int unsigned       tx_gap_pct;
  int unsigned       rx_stall_pct;
  int unsigned       rx_stall_left;
  int unsigned       rx_cycle;
  bit                rx_idle_on;
  bit                rx_hold_req;
  int unsigned       cycle_count;

  // stimulus locals
  int unsigned       sent;
  int unsigned       lit_idx;
  int unsigned       len;
  int unsigned       form;
  int unsigned       d;
  logic              neg_ok;

  integer_literal_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.parsed_ok  = m_axis_tuser[0];
      observed.overflowed = m_axis_tuser[1];
      observed.number     = m_axis_tdata[31:0];
      observed.consumed   = m_axis_tdata[39:32];
      sb.check_result(observed);
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_cycle % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_stall_pct = 0;
          1:       rx_stall_pct = 10;
          default: rx_stall_pct = 30;
        endcase
      end
      rx_cycle++;
      if (rx_hold_req) begin
        rx_hold_req   = 1'b0;
        rx_stall_left = LongHold;
      end else if (rx_stall_left == 0 && rx_idle_on &&
                   $urandom_range(0, 99) < rx_stall_pct) begin
        rx_stall_left = $urandom_range(1, 10);
      end
      if (rx_stall_left != 0) begin
        m_axis_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Send one character; starts and ends at a falling edge
  task automatic send_char(input logic [7:0] c, input logic start, input logic allow);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= {allow, start};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(c, start, allow);
    @(negedge clk_i);
  endtask

  // Send lit_q as one literal, start flag on its first character
  task automatic send_chars(input logic allow);
    foreach (lit_q[i])
      send_char(lit_q[i], i == 0, (i == 0) ? allow : 1'($urandom_range(0, 1)));
  endtask

  task automatic load_text(input string s);
    lit_q.delete();
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    tx_gap_pct    = 0;
    rx_stall_pct  = 0;
    rx_stall_left = 0;
    rx_cycle      = 0;
    rx_idle_on    = 1'b1;
    rx_hold_req   = 1'b0;
    cycle_count   = 0;
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed literals
    tx_gap_pct = 20;
    load_text("-");       send_chars(1'b0);  // sign not allowed: null result
    load_text("-9");      lit_q.push_back(ChNul);
    send_chars(1'b1);                        // negative, ended by end of string
    load_text("0xg");     send_chars(1'b0);  // hex prefix without digit
    load_text("0b2");     send_chars(1'b1);  // binary prefix without digit
    load_text("0b101 ");  send_chars(1'b0);
    load_text("07");      lit_q.push_back(8'hFF);
    send_chars(1'b0);                        // leading zero then decimal
    load_text("0xFf.");   send_chars(1'b1);  // mixed-case hex
    load_text("5");       send_chars(1'b0);  // abandoned by the next start
    load_text("x");       send_chars(1'b0);  // no digit at all: null
    send_char(ChLowA, 1'b0, 1'b1);           // idle character, ignored

    // Random literal streams
    sent    = 0;
    lit_idx = 0;
    while (sent < RandomItems) begin
      neg_ok = 1'($urandom_range(0, 1));
      if (sent + 150 > RandomItems) begin
        // tail of the run: no idling
        tx_gap_pct = 0;
        rx_idle_on = 1'b0;
      end else if (lit_idx % 8 == 0) begin
        case ($urandom_range(0, 2))
          0:       tx_gap_pct = 0;
          1:       tx_gap_pct = 10;
          default: tx_gap_pct = 35;
        endcase
      end
      // long output stall while characters keep coming
      if (lit_idx == 10) rx_hold_req = 1'b1;
      // full drain before going on
      if (lit_idx == 45) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge clk_i);
        repeat (4) @(negedge clk_i);
      end

      // sign, allowed or not
      lit_q.delete();
      if (neg_ok && $urandom_range(0, 2) == 0) lit_q.push_back(ChMinus);
      else if ($urandom_range(0, 19) == 0) lit_q.push_back(ChMinus);
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 22) : $urandom_range(1, 6);
      form = $urandom_range(0, 9);
      // one very long decimal literal, which can saturate the consumed count
      if (lit_idx == 30) begin
        len  = $urandom_range(250, 270);
        form = 0;
      end
      case (form)
        0, 1, 2: begin
          if ($urandom_range(0, 3) == 0) lit_q.push_back(ChZero);
          repeat (len) lit_q.push_back(8'(ChZero + $urandom_range(0, 9)));
        end
        3, 4: begin
          lit_q.push_back(ChZero);
          lit_q.push_back(ChLowX);
          repeat (len) begin
            d = $urandom_range(0, 15);
            if (d < 10) lit_q.push_back(8'(ChZero + d));
            else lit_q.push_back(8'(($urandom_range(0, 1) ? ChUpA : ChLowA) + d - 10));
          end
        end
        5, 6: begin
          lit_q.push_back(ChZero);
          lit_q.push_back(ChLowB);
          repeat (len * 3) lit_q.push_back(8'(ChZero + $urandom_range(0, 1)));
        end
        7: begin
          // bare prefix, the stop character decides
          lit_q.push_back(ChZero);
          lit_q.push_back($urandom_range(0, 1) ? ChLowX : ChLowB);
        end
        8: lit_q.push_back(ChZero);
        default: ;  // sign at most
      endcase

      // stop character; sometimes none, so the next start abandons it
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 3) == 0) lit_q.push_back(8'($urandom_range(0, 255)));
        else begin
          case ($urandom_range(0, 3))
            0:       lit_q.push_back(ChNul);
            1:       lit_q.push_back(ChSpace);
            2:       lit_q.push_back(ChComma);
            default: lit_q.push_back(ChLowG);
          endcase
        end
      end
      send_chars(neg_ok);
      sent += lit_q.size();

      // stray characters without start
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 3))
          send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      lit_idx++;
    end

    // Drain and settle
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ilp_pkg.sv
hdl/ilp_in_stage.sv
hdl/ilp_core.sv
hdl/ilp_out_stage.sv
hdl/integer_literal_parser.sv
dv/tb_integer_literal_parser.sv
